@@ rtl/core/fit_pkg.sv @@
// fit_pkg: shared types, constants and address helpers for the four-index transform unit.
// No dependencies; imported by every module of the block.
package fit_pkg;

    // sizing
    localparam int MAX_DIM = 8;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 64;
    localparam int CIDX_W  = 2;
    localparam int ADIM_W  = 4;
    localparam int T_DEPTH = MAX_DIM * MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int C_DEPTH = MAX_DIM * MAX_DIM;
    localparam int TA_W    = $clog2(T_DEPTH);
    localparam int CA_W    = $clog2(C_DEPTH);
    localparam int M_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int N_W     = $clog2(MAX_DIM + 1);

    // fixed point limits
    localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] NEG_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // configuration reset values
    localparam logic [CIDX_W-1:0] CIDX_RESET = '0;
    localparam logic [ADIM_W-1:0] ADIM_RESET = 4'd8;

    // item operation codes
    typedef logic [1:0] t_func;
    localparam t_func FUNC_LOAD_T  = 2'd0;
    localparam t_func FUNC_LOAD_C  = 2'd1;
    localparam t_func FUNC_COMPUTE = 2'd2;

    typedef struct packed {
        t_func                    func;
        logic [IDX_W-1:0]         idx_first;
        logic [IDX_W-1:0]         idx_second;
        logic [IDX_W-1:0]         idx_third;
        logic [IDX_W-1:0]         idx_fourth;
        logic signed [DATA_W-1:0] data_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] element_value;
        logic                     saturated;
    } t_out_item;

    typedef struct packed {
        logic [CIDX_W-1:0] contracted_index;
        logic [ADIM_W-1:0] active_dim;
    } t_cfg;

    // store write and read requests
    typedef struct packed {
        logic              t_wr;
        logic              c_wr;
        logic [TA_W-1:0]   t_addr;
        logic [CA_W-1:0]   c_addr;
        logic [DATA_W-1:0] data;
    } t_wr_req;

    typedef struct packed {
        logic            en;
        logic [TA_W-1:0] t_addr;
        logic [CA_W-1:0] c_addr;
    } t_rd_req;

    // one clipped product from the multiplier
    typedef struct packed {
        logic              vld;
        logic              last;
        logic              clip;
        logic [DATA_W-1:0] value;
    } t_prod;

    function automatic logic idx_ok(input logic [IDX_W-1:0] v);
        return {1'b0, v} < (IDX_W+1)'(MAX_DIM);
    endfunction

    function automatic logic [TA_W-1:0] fit_t_addr(input logic [IDX_W-1:0] a,
                                                   input logic [IDX_W-1:0] b,
                                                   input logic [IDX_W-1:0] c,
                                                   input logic [IDX_W-1:0] d);
        int sum;
        sum = ((int'(a) * MAX_DIM + int'(b)) * MAX_DIM + int'(c)) * MAX_DIM + int'(d);
        return TA_W'(sum);
    endfunction

    function automatic logic [CA_W-1:0] fit_c_addr(input logic [IDX_W-1:0] m,
                                                   input logic [IDX_W-1:0] e);
        int sum;
        sum = int'(m) * MAX_DIM + int'(e);
        return CA_W'(sum);
    endfunction

endpackage

@@ rtl/core/four_index_integral_transform_unit.sv @@
// four_index_integral_transform_unit: top level with item channels, register port and
// output register. Depends on fit_pkg, fit_store, fit_qmul and fit_seq.
//
// Load items (tensor entry or coefficient) write one memory entry if their indices are
// in range. A compute item returns base + sum over m < n of C(m,e) * T(..) with m placed
// in the contracted position, where n is active_dim clipped to 8; from its acceptance the
// input stays stalled through one tensor/coefficient read per summation step from the
// synchronous memories, the registered read, the four-stage multiplier, the accumulate
// step and the hand-off to the output register. An out-of-range or empty-sum compute item
// skips the reads and goes straight to the hand-off. The result waits in the output
// register, so a new item is accepted while an earlier result is still stalled; a finished
// compute whose result finds that register full and stalled keeps the input stalled until
// it moves. Memories are not cleared by reset and must be written before they are read.
module four_index_integral_transform_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  fit_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output fit_pkg::t_out_item   o_out_item,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import fit_pkg::*;

    localparam logic REG_CONTRACTED = 1'b0;
    localparam logic REG_ACTIVE_DIM = 1'b1;

    logic [CIDX_W-1:0] r_contracted_index;
    logic [ADIM_W-1:0] r_active_dim;
    logic              r_out_vld;
    t_out_item         r_out_item;

    t_cfg              cfg;
    t_wr_req           wr;
    t_rd_req           rd;
    t_prod             prod;
    t_out_item         res;
    logic [DATA_W-1:0] t_data, c_data;
    logic              busy, res_vld, mul_vld, mul_last;
    logic              accept, start, out_load, cfg_wr;
    logic              reg_sel;

    // register port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_contracted_index <= CIDX_RESET;
            r_active_dim       <= ADIM_RESET;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_CONTRACTED: r_contracted_index <= pwdata[CIDX_W-1:0];
                REG_ACTIVE_DIM: r_active_dim       <= pwdata[ADIM_W-1:0];
                default:        r_active_dim       <= r_active_dim;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_CONTRACTED: prdata = {{(32-CIDX_W){1'b0}}, r_contracted_index};
            REG_ACTIVE_DIM: prdata = {{(32-ADIM_W){1'b0}}, r_active_dim};
            default:        prdata = '0;
        endcase
    end

    assign cfg.contracted_index = r_contracted_index;
    assign cfg.active_dim       = r_active_dim;

    // input item decode
    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;
    assign start      = accept && (i_in_item.func == FUNC_COMPUTE);

    always_comb begin
        wr.t_wr   = accept && (i_in_item.func == FUNC_LOAD_T) &&
                    idx_ok(i_in_item.idx_first) && idx_ok(i_in_item.idx_second) &&
                    idx_ok(i_in_item.idx_third) && idx_ok(i_in_item.idx_fourth);
        wr.c_wr   = accept && (i_in_item.func == FUNC_LOAD_C) &&
                    idx_ok(i_in_item.idx_first) && idx_ok(i_in_item.idx_second);
        wr.t_addr = fit_t_addr(i_in_item.idx_first, i_in_item.idx_second,
                               i_in_item.idx_third, i_in_item.idx_fourth);
        wr.c_addr = fit_c_addr(i_in_item.idx_first, i_in_item.idx_second);
        wr.data   = i_in_item.data_value;
    end

    fit_store u_store (
        .i_clk    (i_clk),
        .i_wr     (wr),
        .i_rd     (rd),
        .o_t_data (t_data),
        .o_c_data (c_data)
    );

    fit_qmul u_qmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (mul_vld),
        .i_last  (mul_last),
        .i_a     (c_data),
        .i_b     (t_data),
        .o_prod  (prod)
    );

    fit_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_item     (i_in_item),
        .i_cfg      (cfg),
        .i_prod     (prod),
        .i_take     (out_load),
        .o_busy     (busy),
        .o_rd       (rd),
        .o_mul_vld  (mul_vld),
        .o_mul_last (mul_last),
        .o_res_vld  (res_vld),
        .o_res      (res)
    );

    // output register
    assign out_load = res_vld && (!r_out_vld || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

endmodule

@@ rtl/core/fit_store.sv @@
// fit_store: tensor and coefficient memories, one write and one registered read each.
// Depends on fit_pkg.
module fit_store (
    input  logic                      i_clk,
    input  fit_pkg::t_wr_req          i_wr,
    input  fit_pkg::t_rd_req          i_rd,
    output logic [fit_pkg::DATA_W-1:0] o_t_data,
    output logic [fit_pkg::DATA_W-1:0] o_c_data
);
    import fit_pkg::*;

    logic [DATA_W-1:0] r_tensor [T_DEPTH];
    logic [DATA_W-1:0] r_coef   [C_DEPTH];
    logic [DATA_W-1:0] r_t_rd;
    logic [DATA_W-1:0] r_c_rd;

    // tensor memory
    always_ff @(posedge i_clk) begin
        if (i_wr.t_wr) begin
            r_tensor[i_wr.t_addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_t_rd <= r_tensor[i_rd.t_addr];
        end
    end

    // coefficient memory
    always_ff @(posedge i_clk) begin
        if (i_wr.c_wr) begin
            r_coef[i_wr.c_addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_c_rd <= r_coef[i_rd.c_addr];
        end
    end

    assign o_t_data = r_t_rd;
    assign o_c_data = r_c_rd;

endmodule

@@ rtl/core/fit_qmul.sv @@
// fit_qmul: four-stage Q23.40 multiplier, truncating toward zero and clipping to 64 bits.
// Built from 32x32 partial products; depends on fit_pkg.
module fit_qmul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  logic                       i_last,
    input  logic [fit_pkg::DATA_W-1:0] i_a,
    input  logic [fit_pkg::DATA_W-1:0] i_b,
    output fit_pkg::t_prod             o_prod
);
    import fit_pkg::*;

    localparam int HW    = DATA_W / 2;
    localparam int FW    = 2 * DATA_W;
    localparam int FRAC  = 40;
    localparam int Q_W   = FW - FRAC;

    // stage 1: sign and magnitudes
    logic              r_s1_vld, r_s1_last, r_s1_neg;
    logic [DATA_W-1:0] r_s1_ax, r_s1_ay;
    // stage 2: partial products
    logic              r_s2_vld, r_s2_last, r_s2_neg;
    logic [DATA_W-1:0] r_p00, r_p01, r_p10, r_p11;
    // stage 3: shifted magnitude
    logic              r_s3_vld, r_s3_last, r_s3_neg;
    logic [Q_W-1:0]    r_q;
    // stage 4: clipped signed product
    logic              r_s4_vld, r_s4_last, r_s4_clip;
    logic [DATA_W-1:0] r_s4_val;

    logic [FW-1:0]     full;
    logic [DATA_W-1:0] lim, mag;
    logic              clip;

    // valid and last flags through the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    // product sum and clip logic
    always_comb begin
        full = {r_p11, {DATA_W{1'b0}}}
             + {{HW{1'b0}}, r_p01, {HW{1'b0}}}
             + {{HW{1'b0}}, r_p10, {HW{1'b0}}}
             + {{DATA_W{1'b0}}, r_p00};
        lim  = r_s3_neg ? NEG_MIN : POS_MAX;
        clip = (|r_q[Q_W-1:DATA_W]) || (r_q[DATA_W-1:0] > lim);
        mag  = clip ? lim : r_q[DATA_W-1:0];
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_s1_last <= i_last;
        r_s1_neg  <= i_a[DATA_W-1] ^ i_b[DATA_W-1];
        r_s1_ax   <= i_a[DATA_W-1] ? (~i_a + 1'b1) : i_a;
        r_s1_ay   <= i_b[DATA_W-1] ? (~i_b + 1'b1) : i_b;

        r_s2_last <= r_s1_last;
        r_s2_neg  <= r_s1_neg;
        r_p00     <= r_s1_ax[HW-1:0]      * r_s1_ay[HW-1:0];
        r_p01     <= r_s1_ax[HW-1:0]      * r_s1_ay[DATA_W-1:HW];
        r_p10     <= r_s1_ax[DATA_W-1:HW] * r_s1_ay[HW-1:0];
        r_p11     <= r_s1_ax[DATA_W-1:HW] * r_s1_ay[DATA_W-1:HW];

        r_s3_last <= r_s2_last;
        r_s3_neg  <= r_s2_neg;
        r_q       <= full[FW-1:FRAC];

        r_s4_last <= r_s3_last;
        r_s4_clip <= clip;
        r_s4_val  <= r_s3_neg ? (~mag + 1'b1) : mag;
    end

    assign o_prod.vld   = r_s4_vld;
    assign o_prod.last  = r_s4_last;
    assign o_prod.clip  = r_s4_clip;
    assign o_prod.value = r_s4_val;

endmodule

@@ rtl/core/fit_seq.sv @@
// fit_seq: sequencer for one compute item: issues store reads per summation step and
// accumulates clipped products with saturation. Depends on fit_pkg.
module fit_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  fit_pkg::t_in_item          i_item,
    input  fit_pkg::t_cfg              i_cfg,
    input  fit_pkg::t_prod             i_prod,
    input  logic                       i_take,
    output logic                       o_busy,
    output fit_pkg::t_rd_req           o_rd,
    output logic                       o_mul_vld,
    output logic                       o_mul_last,
    output logic                       o_res_vld,
    output fit_pkg::t_out_item         o_res
);
    import fit_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [M_W-1:0]    r_m, n_m;
    logic [DATA_W-1:0] r_acc, n_acc;
    logic              r_sat, n_sat;
    logic              r_rd_vld, r_rd_last;

    // latched item context
    logic [IDX_W-1:0]  r_v [4];
    logic [CIDX_W-1:0] r_pos;
    logic [IDX_W-1:0]  r_e;
    logic [N_W-1:0]    r_n;

    logic [IDX_W-1:0]  v_in [4];
    logic [IDX_W-1:0]  w [4];
    logic [N_W-1:0]    n_cfg;
    logic              in_range, start_ok, issue, issue_last;
    logic [DATA_W-1:0] sum;
    logic              ovf;

    // incoming indices and summation length
    always_comb begin
        v_in[0]  = i_item.idx_first;
        v_in[1]  = i_item.idx_second;
        v_in[2]  = i_item.idx_third;
        v_in[3]  = i_item.idx_fourth;
        in_range = idx_ok(v_in[0]) && idx_ok(v_in[1]) && idx_ok(v_in[2]) && idx_ok(v_in[3]);
        n_cfg    = ({1'b0, i_cfg.active_dim} > (ADIM_W+1)'(MAX_DIM)) ?
                   N_W'(MAX_DIM) : N_W'(i_cfg.active_dim);
        start_ok = in_range && (n_cfg != '0);
    end

    // read address for step m: m replaces the contracted index
    always_comb begin
        w[0] = r_v[0];
        w[1] = r_v[1];
        w[2] = r_v[2];
        w[3] = r_v[3];
        w[r_pos] = IDX_W'(r_m);
        issue      = (r_state == S_ISSUE);
        issue_last = ((N_W'(r_m) + 1'b1) == r_n);
    end

    assign o_rd.en     = issue;
    assign o_rd.t_addr = fit_t_addr(w[0], w[1], w[2], w[3]);
    assign o_rd.c_addr = fit_c_addr(IDX_W'(r_m), r_e);

    // saturating accumulate
    always_comb begin
        sum = r_acc + i_prod.value;
        ovf = (r_acc[DATA_W-1] == i_prod.value[DATA_W-1]) &&
              (sum[DATA_W-1] != r_acc[DATA_W-1]);
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_m     = r_m;
        n_acc   = r_acc;
        n_sat   = r_sat;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_acc   = i_item.data_value;
                    n_sat   = 1'b0;
                    n_m     = '0;
                    n_state = start_ok ? S_ISSUE : S_DONE;
                end
            end
            S_ISSUE: begin
                n_m = r_m + 1'b1;
                if (issue_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = r_state;
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_prod.vld) begin
            n_acc = ovf ? (r_acc[DATA_W-1] ? NEG_MIN : POS_MAX) : sum;
            n_sat = r_sat | i_prod.clip | ovf;
            if (i_prod.last) begin
                n_state = S_DONE;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= issue;
            r_rd_last <= issue && issue_last;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_m   <= n_m;
        r_acc <= n_acc;
        r_sat <= n_sat;
        if (i_start && (r_state == S_IDLE)) begin
            r_v[0] <= v_in[0];
            r_v[1] <= v_in[1];
            r_v[2] <= v_in[2];
            r_v[3] <= v_in[3];
            r_pos  <= i_cfg.contracted_index;
            r_e    <= v_in[i_cfg.contracted_index];
            r_n    <= n_cfg;
        end
    end

    assign o_busy              = (r_state != S_IDLE);
    assign o_mul_vld           = r_rd_vld;
    assign o_mul_last          = r_rd_last;
    assign o_res_vld           = (r_state == S_DONE);
    assign o_res.element_value = r_acc;
    assign o_res.saturated     = r_sat;

endmodule

@@ rtl/core/fit_checker.sv @@
// fit_checker: port-level assertions for the four-index transform unit, with its bind.
// Depends on fit_pkg and four_index_integral_transform_unit.
module fit_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input fit_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input fit_pkg::t_out_item o_out_item
);
    import fit_pkg::*;

    // reset empties the output register and frees the input side
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output valid or input stall set after reset");

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result item dropped or changed while stalled");

    // a compute item occupies the block on the next cycle
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_item.func == FUNC_COMPUTE) |=> o_in_stall)
        else $error("input not stalled after a compute item");

    // a new result only appears at the end of a compute
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result item appeared without a compute in progress");

endmodule

bind four_index_integral_transform_unit fit_checker u_fit_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
